### hdl/mcet_pkg.sv
// Shared widths, constants and the month-start table for the expiry time block.
`timescale 1ns / 1ps

package mcet_pkg;

   // Field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int NOW_W   = 40;
   localparam int SEC_W   = 38;

   // Internal widths
   localparam int DAYS_W  = 23;   // days since epoch, up to year 16383
   localparam int LEAP_W  = 13;   // y/4 - y/100 + y/400
   localparam int WSUM_W  = 15;   // weekday sum before mod 7
   localparam int DOY_W   = 9;    // day of March-based year at month start
   localparam int PROD_W  = 40;   // days times seconds per day
   localparam int WDAY_W  = 3;
   localparam int MDAY_W  = 5;

   // Calendar constants
   localparam int EPOCH_YEAR    = 1970;
   localparam int EPOCH_DAYS    = 719468;  // March-based day count of 1970-01-01
   localparam int DAYS_PER_YEAR = 365;
   localparam int SEC_PER_DAY   = 86400;
   localparam int SEC_PER_HOUR  = 3600;
   localparam int UTC_HOUR_DST  = 20;      // 16:00 at UTC-4
   localparam int UTC_HOUR_STD  = 21;      // 16:00 at UTC-5
   localparam int MIN_LEFT      = 60;
   localparam int INVALID_LEFT  = 86400;
   localparam int DAYS_PER_WEEK = 7;

   // Month codes
   localparam int MONTH_JAN = 1;
   localparam int MONTH_FEB = 2;
   localparam int MONTH_MAR = 3;
   localparam int MONTH_APR = 4;
   localparam int MONTH_MAY = 5;
   localparam int MONTH_JUN = 6;
   localparam int MONTH_JUL = 7;
   localparam int MONTH_AUG = 8;
   localparam int MONTH_SEP = 9;
   localparam int MONTH_OCT = 10;
   localparam int MONTH_NOV = 11;
   localparam int MONTH_DEC = 12;

   // Sakamoto key of March and November (both 2) plus day 1
   localparam int WDAY_OFFSET = 3;

   // Reciprocals for constant division: x/25 exact for x < 4681, x/7 for x < 43691
   localparam int RECIP_25       = 1311;
   localparam int RECIP_25_SHIFT = 15;
   localparam int RECIP_7        = 37450;
   localparam int RECIP_7_SHIFT  = 18;

   typedef logic [YEAR_W-1:0]  year_type;
   typedef logic [MONTH_W-1:0] month_type;
   typedef logic [DAY_W-1:0]   day_type;
   typedef logic [NOW_W-1:0]   now_type;
   typedef logic [SEC_W-1:0]   sec_type;
   typedef logic [LEAP_W-1:0]  leap_type;

   // Days from March 1 to the first of month m (March-based year)
   function automatic logic [DOY_W-1:0] month_start_doy(input month_type m);
      logic [DOY_W-1:0] doy;
      doy = '0;
      unique case (m)
         month_type'(MONTH_MAR): doy = DOY_W'(0);
         month_type'(MONTH_APR): doy = DOY_W'(31);
         month_type'(MONTH_MAY): doy = DOY_W'(61);
         month_type'(MONTH_JUN): doy = DOY_W'(92);
         month_type'(MONTH_JUL): doy = DOY_W'(122);
         month_type'(MONTH_AUG): doy = DOY_W'(153);
         month_type'(MONTH_SEP): doy = DOY_W'(184);
         month_type'(MONTH_OCT): doy = DOY_W'(214);
         month_type'(MONTH_NOV): doy = DOY_W'(245);
         month_type'(MONTH_DEC): doy = DOY_W'(275);
         month_type'(MONTH_JAN): doy = DOY_W'(306);
         month_type'(MONTH_FEB): doy = DOY_W'(337);
         default:                doy = '0;
      endcase
      return doy;
   endfunction

endpackage

### hdl/mcet_if.sv
// Request and response channel interfaces for the expiry time block.
`timescale 1ns / 1ps

interface mcet_req_if;
   import mcet_pkg::*;

   logic      valid;
   logic      ready;
   year_type  exp_year;
   month_type exp_month;
   day_type   exp_day;
   now_type   now_seconds;

   modport source (output valid, exp_year, exp_month, exp_day, now_seconds, input ready);
   modport sink   (input valid, exp_year, exp_month, exp_day, now_seconds, output ready);
endinterface

interface mcet_rsp_if;
   import mcet_pkg::*;

   logic    valid;
   logic    ready;
   logic    date_valid;
   logic    is_dst;
   sec_type expiry_seconds;
   sec_type seconds_left;

   modport source (output valid, date_valid, is_dst, expiry_seconds, seconds_left,
                   input ready);
   modport sink   (input valid, date_valid, is_dst, expiry_seconds, seconds_left,
                   output ready);
endinterface

### hdl/mcet_leap_count.sv
// Gregorian leap-day count y/4 - y/100 + y/400 by reciprocal multiplication.
`timescale 1ns / 1ps

module mcet_leap_count (
   input  mcet_pkg::year_type year,
   output mcet_pkg::leap_type leap
);
   import mcet_pkg::*;

   localparam int Q4_W   = YEAR_W - 2;
   localparam int Q16_W  = YEAR_W - 4;
   localparam int P100_W = Q4_W + 11;
   localparam int P400_W = Q16_W + 11;

   logic [Q4_W-1:0]   q4;
   logic [Q16_W-1:0]  q16;
   logic [P100_W-1:0] prod100;
   logic [P400_W-1:0] prod400;

   // Divide by 4 and 16 with shifts, then by 25 with a reciprocal
   assign q4      = year[YEAR_W-1:2];
   assign q16     = year[YEAR_W-1:4];
   assign prod100 = P100_W'(q4) * P100_W'(RECIP_25);
   assign prod400 = P400_W'(q16) * P400_W'(RECIP_25);

   assign leap = LEAP_W'(q4)
               - LEAP_W'(prod100[P100_W-1:RECIP_25_SHIFT])
               + LEAP_W'(prod400[P400_W-1:RECIP_25_SHIFT]);

endmodule

### hdl/market_close_expiry_time.sv
// Top level: date to 16:00 US Eastern close in UTC epoch seconds, five-stage pipeline.
`timescale 1ns / 1ps

// Each request carries an expiry date and the current UTC second and yields one response,
// with a new request taken in every cycle unless a stalled response backs up to the
// request side. The five register stages are the leap counts, the day and weekday sums,
// the two constant multiplies, the daylight-time decision with the hour added, then the
// seconds-left compare. Every stage has its own valid bit and loads when it is empty or
// its successor moves on, so a stalled response holds the last stage and each earlier
// stage keeps filling while it is empty. A date is valid when the year is above 1970,
// the month is 1 to 12 and the day is nonzero; an invalid date gives date_valid 0,
// is_dst 0, expiry_seconds 0 and seconds_left 86400. Days past a month's end carry into
// the next month, while the daylight-time decision uses the month and day as given.
// expiry_seconds saturates at its field's maximum, and seconds_left never drops below 60.
module market_close_expiry_time (
   input  logic        clock,
   input  logic        reset,
   mcet_req_if.sink    req_ch,
   mcet_rsp_if.source  rsp_ch
);
   import mcet_pkg::*;

   localparam int NSTG    = 5;
   localparam int DSUM_W  = DAYS_W + 1;
   localparam int Q7P_W   = WSUM_W + 16;
   localparam int Q7_W    = Q7P_W - RECIP_7_SHIFT;
   localparam int EXPF_W  = PROD_W + 1;

   // Stage handshake
   logic [NSTG-1:0] stg_valid_ff;
   logic [NSTG-1:0] stg_load;

   // Load a stage when it is empty or its contents move on
   always_comb begin
      stg_load[NSTG-1] = !stg_valid_ff[NSTG-1] || rsp_ch.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stg_load[k] = !stg_valid_ff[k] || stg_load[k+1];
      end
   end

   assign req_ch.ready = stg_load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         if (stg_load[0]) begin
            stg_valid_ff[0] <= req_ch.valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (stg_load[k]) begin
               stg_valid_ff[k] <= stg_valid_ff[k-1];
            end
         end
      end
   end

   // ---------------- Stage 1: range check and leap counts ----------------
   year_type  yy_in;
   logic      ok1_in;
   leap_type  leapy1_in;
   leap_type  leapyy1_in;

   year_type  y1_ff, yy1_ff;
   month_type m1_ff;
   day_type   d1_ff;
   now_type   now1_ff;
   logic      ok1_ff;
   leap_type  leapy1_ff, leapyy1_ff;

   // January and February count in the previous March-based year
   assign yy_in = (req_ch.exp_month <= month_type'(MONTH_FEB)) ?
                  req_ch.exp_year - YEAR_W'(1) : req_ch.exp_year;

   assign ok1_in = (req_ch.exp_year > YEAR_W'(EPOCH_YEAR))
                && (req_ch.exp_month >= month_type'(MONTH_JAN))
                && (req_ch.exp_month <= month_type'(MONTH_DEC))
                && (req_ch.exp_day != '0);

   mcet_leap_count u_leap_y (
      .year (req_ch.exp_year),
      .leap (leapy1_in)
   );

   mcet_leap_count u_leap_yy (
      .year (yy_in),
      .leap (leapyy1_in)
   );

   always_ff @(posedge clock) begin
      if (stg_load[0]) begin
         y1_ff      <= req_ch.exp_year;
         yy1_ff     <= yy_in;
         m1_ff      <= req_ch.exp_month;
         d1_ff      <= req_ch.exp_day;
         now1_ff    <= req_ch.now_seconds;
         ok1_ff     <= ok1_in;
         leapy1_ff  <= leapy1_in;
         leapyy1_ff <= leapyy1_in;
      end
   end

   // ---------------- Stage 2: weekday sum and day count ----------------
   logic [WSUM_W-1:0] wsum2_in;
   logic [DSUM_W-1:0] dsum2;
   logic [DAYS_W-1:0] days2_in;

   logic [WSUM_W-1:0] wsum2_ff;
   logic [DAYS_W-1:0] days2_ff;
   month_type         m2_ff;
   day_type           d2_ff;
   now_type           now2_ff;
   logic              ok2_ff;

   // Sakamoto sum for the first of March or November of the same year
   assign wsum2_in = WSUM_W'(y1_ff) + WSUM_W'(leapy1_ff) + WSUM_W'(WDAY_OFFSET);

   // Days since epoch: 365*yy + leap days + month start + day - 1, less the epoch
   assign dsum2 = DSUM_W'(yy1_ff) * DSUM_W'(DAYS_PER_YEAR)
                + DSUM_W'(leapyy1_ff)
                + DSUM_W'(month_start_doy(m1_ff))
                + DSUM_W'(d1_ff)
                - DSUM_W'(1)
                - DSUM_W'(EPOCH_DAYS);
   assign days2_in = dsum2[DAYS_W-1:0];

   always_ff @(posedge clock) begin
      if (stg_load[1]) begin
         wsum2_ff <= wsum2_in;
         days2_ff <= days2_in;
         m2_ff    <= m1_ff;
         d2_ff    <= d1_ff;
         now2_ff  <= now1_ff;
         ok2_ff   <= ok1_ff;
      end
   end

   // ---------------- Stage 3: divide by seven, scale days to seconds ----------------
   logic [Q7P_W-1:0]  q7prod;
   logic [Q7_W-1:0]   q7_3_in;
   logic [PROD_W-1:0] secs3_in;

   logic [Q7_W-1:0]   q7_3_ff;
   logic [PROD_W-1:0] secs3_ff;
   logic [WSUM_W-1:0] wsum3_ff;
   month_type         m3_ff;
   day_type           d3_ff;
   now_type           now3_ff;
   logic              ok3_ff;

   assign q7prod   = Q7P_W'(wsum2_ff) * Q7P_W'(RECIP_7);
   assign q7_3_in  = q7prod[Q7P_W-1:RECIP_7_SHIFT];
   assign secs3_in = PROD_W'(days2_ff) * PROD_W'(SEC_PER_DAY);

   always_ff @(posedge clock) begin
      if (stg_load[2]) begin
         q7_3_ff  <= q7_3_in;
         secs3_ff <= secs3_in;
         wsum3_ff <= wsum2_ff;
         m3_ff    <= m2_ff;
         d3_ff    <= d2_ff;
         now3_ff  <= now2_ff;
         ok3_ff   <= ok2_ff;
      end
   end

   // ---------------- Stage 4: daylight time and expiry second ----------------
   logic [WSUM_W-1:0] wrem;
   logic [WDAY_W-1:0] wday;
   logic [MDAY_W-1:0] first_sun;
   logic [MDAY_W-1:0] second_sun;
   logic              dst4_in;
   logic [EXPF_W-1:0] expf;
   sec_type           exp4_in;

   logic              dst4_ff;
   sec_type           exp4_ff;
   now_type           now4_ff;
   logic              ok4_ff;

   // Weekday of March 1 and November 1 of the year, 0 is Sunday
   assign wrem = wsum3_ff - WSUM_W'(q7_3_ff) * WSUM_W'(DAYS_PER_WEEK);
   assign wday = wrem[WDAY_W-1:0];

   assign first_sun  = (wday == '0) ? MDAY_W'(1) : MDAY_W'(DAYS_PER_WEEK + 1) - MDAY_W'(wday);
   assign second_sun = first_sun + MDAY_W'(DAYS_PER_WEEK);

   // On from the second Sunday of March, off from the first Sunday of November
   always_comb begin
      dst4_in = 1'b0;
      if (m3_ff > month_type'(MONTH_MAR) && m3_ff < month_type'(MONTH_NOV)) begin
         dst4_in = 1'b1;
      end else if (m3_ff == month_type'(MONTH_MAR)) begin
         dst4_in = MDAY_W'(d3_ff) >= second_sun;
      end else if (m3_ff == month_type'(MONTH_NOV)) begin
         dst4_in = MDAY_W'(d3_ff) < first_sun;
      end
   end

   // Add the close hour in UTC and saturate to the field
   assign expf = EXPF_W'(secs3_ff)
               + (dst4_in ? EXPF_W'(UTC_HOUR_DST * SEC_PER_HOUR)
                          : EXPF_W'(UTC_HOUR_STD * SEC_PER_HOUR));
   assign exp4_in = (expf[EXPF_W-1:SEC_W] != '0) ? '1 : expf[SEC_W-1:0];

   always_ff @(posedge clock) begin
      if (stg_load[3]) begin
         dst4_ff <= dst4_in;
         exp4_ff <= exp4_in;
         now4_ff <= now3_ff;
         ok4_ff  <= ok3_ff;
      end
   end

   // ---------------- Stage 5: seconds left, invalid override ----------------
   logic [NOW_W-1:0] diff5;
   logic             ahead5;
   logic             valid5_in;
   logic             dst5_in;
   sec_type          exp5_in;
   sec_type          left5_in;

   logic             valid5_ff;
   logic             dst5_ff;
   sec_type          exp5_ff;
   sec_type          left5_ff;

   assign diff5  = NOW_W'(exp4_ff) - now4_ff;
   assign ahead5 = (NOW_W'(exp4_ff) > now4_ff) && (diff5 > NOW_W'(MIN_LEFT));

   always_comb begin
      valid5_in = ok4_ff;
      dst5_in   = dst4_ff;
      exp5_in   = exp4_ff;
      left5_in  = ahead5 ? diff5[SEC_W-1:0] : SEC_W'(MIN_LEFT);
      if (!ok4_ff) begin
         dst5_in  = 1'b0;
         exp5_in  = '0;
         left5_in = SEC_W'(INVALID_LEFT);
      end
   end

   always_ff @(posedge clock) begin
      if (stg_load[4]) begin
         valid5_ff <= valid5_in;
         dst5_ff   <= dst5_in;
         exp5_ff   <= exp5_in;
         left5_ff  <= left5_in;
      end
   end

   // Drive the response channel from the last stage
   assign rsp_ch.valid          = stg_valid_ff[NSTG-1];
   assign rsp_ch.date_valid     = valid5_ff;
   assign rsp_ch.is_dst         = dst5_ff;
   assign rsp_ch.expiry_seconds = exp5_ff;
   assign rsp_ch.seconds_left   = left5_ff;

endmodule
